// ----- src/mrgf_pkg.sv -----
// Shared types, register codes and constants of the reach-grid Metropolis block.
package mrgf_pkg;

  localparam int GRID_SIDE_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_WEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BUILDINGS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_AMP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_RATE       = 3'd4;

  localparam int REACH_W = 6;
  localparam int DIST_W  = 6;

  // Energy is held as a saturated signed value in units of 1/256.
  localparam int E_W = 25;
  localparam logic signed [E_W-1:0] E_MAX = 25'sh0FFFFFF;
  localparam logic signed [E_W-1:0] E_MIN = 25'sh1000000;

  // Exponential unit: Q.8 argument, saturated at the point where the result is zero.
  localparam int EXP_IN_W  = 13;
  localparam int EXP_LIMIT = 4096;
  localparam int EXP_STEPS = 12;
  localparam int G_W       = 17;

  typedef struct packed {
    logic [4:0]  pos_row;
    logic [4:0]  pos_col;
    logic [15:0] accept_draw;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [18:0] total_links;
    logic [10:0] total_buildings;
  } out_item_t;

  typedef struct packed {
    logic [REACH_W-1:0] reach_limit;
    logic signed [15:0] link_weight;
    logic [10:0]        target_buildings;
    logic signed [15:0] gauss_amp;
    logic [15:0]        gauss_rate;
  } cfg_t;

  typedef struct packed {
    logic update;
    logic undo;
  } grid_req_t;

  typedef struct packed {
    logic ready;
    logic done;
  } grid_stat_t;

  // round(2^24 * exp(-2^k / 256)) for bit k of the Q.8 argument.
  function automatic logic [23:0] exp_tab(input logic [3:0] k);
    logic [23:0] v;
    case (k)
      4'd0:    v = 24'd16711808;
      4'd1:    v = 24'd16646655;
      4'd2:    v = 24'd16517109;
      4'd3:    v = 24'd16261035;
      4'd4:    v = 24'd15760736;
      4'd5:    v = 24'd14805841;
      4'd6:    v = 24'd13066109;
      4'd7:    v = 24'd10175896;
      4'd8:    v = 24'd6171993;
      4'd9:    v = 24'd2270549;
      4'd10:   v = 24'd307285;
      4'd11:   v = 24'd5628;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/mrgf_expneg.sv -----
// Iterative exp(-x) unit: one table factor per cycle over the bits of the argument.
module mrgf_expneg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mrgf_pkg::EXP_IN_W-1:0]    x,
  output logic                             done,
  output logic [mrgf_pkg::G_W-1:0]         val
);

  typedef enum logic [1:0] {X_IDLE, X_RUN, X_FIN} xstate_t;

  xstate_t     state;
  logic [24:0] r;
  logic [11:0] xq;
  logic [3:0]  k;
  logic [48:0] prod;
  logic [48:0] rnd;

  assign prod = 49'(r) * 49'(mrgf_pkg::exp_tab(k));
  assign rnd  = prod + 49'd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= X_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        X_IDLE: begin
          if (start) begin
            if (x[mrgf_pkg::EXP_IN_W-1]) begin
              val  <= '0;
              done <= 1'b1;
            end else begin
              r     <= 25'd16777216;
              k     <= '0;
              xq    <= x[11:0];
              state <= X_RUN;
            end
          end
        end
        X_RUN: begin
          if (xq[k]) begin
            r <= rnd[48:24];
          end
          if (k == 4'(mrgf_pkg::EXP_STEPS - 1)) begin
            state <= X_FIN;
          end else begin
            k <= k + 4'd1;
          end
        end
        X_FIN: begin
          val   <= mrgf_pkg::G_W'((26'(r) + 26'd128) >> 8);
          done  <= 1'b1;
          state <= X_IDLE;
        end
        default: state <= X_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mrgf_energy.sv -----
// Energy evaluation and Metropolis acceptance test around one shared exp unit.
module mrgf_energy #(
  parameter int BW = 11,
  parameter int HW = 19
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start_e,
  input  logic                                start_acc,
  input  mrgf_pkg::cfg_t                      cfg,
  input  logic [BW-1:0]                       bld,
  input  logic [HW-1:0]                       half,
  input  logic signed [mrgf_pkg::E_W:0]       d,
  input  logic [15:0]                         draw,
  output logic                                done,
  output logic signed [mrgf_pkg::E_W-1:0]     e,
  output logic                                acc
);

  localparam int DW  = ((BW > 11) ? BW : 11) + 1;
  localparam int SQW = 2 * DW;
  localparam int XW  = SQW + 16;
  localparam int LPW = 16 + HW + 1;
  localparam int GPW = 16 + mrgf_pkg::G_W + 1;
  localparam int EW  = ((LPW + 1) > 27) ? (LPW + 1) : 27;
  localparam int XIW = mrgf_pkg::EXP_IN_W;

  typedef enum logic [2:0] {E_IDLE, E_SQ, E_RATE, E_WAIT, E_SUM, A_WAIT} estate_t;

  estate_t               state;
  logic signed [DW-1:0]  diff_c;
  logic signed [DW-1:0]  diff_q;
  logic signed [SQW-1:0] sq_c;
  logic [SQW-1:0]        sq_q;
  logic [XW-1:0]         xw_c;
  logic signed [LPW-1:0] lp_c;
  logic signed [LPW-1:0] lprod_q;
  logic signed [GPW-1:0] gp_c;
  logic signed [GPW-1:0] gprod_q;
  logic signed [GPW:0]   gs_c;
  logic signed [EW-1:0]  es_c;
  logic signed [mrgf_pkg::E_W+1:0] nd_c;
  logic                  ex_start;
  logic [XIW-1:0]        ex_x;
  logic                  ex_done;
  logic [mrgf_pkg::G_W-1:0] ex_val;

  assign diff_c = $signed(DW'(bld)) - $signed(DW'(cfg.target_buildings));
  assign sq_c   = diff_q * diff_q;
  assign xw_c   = XW'(sq_q) * XW'(cfg.gauss_rate);
  assign lp_c   = cfg.link_weight * $signed({1'b0, half});
  assign gp_c   = cfg.gauss_amp * $signed({1'b0, ex_val});
  assign gs_c   = gprod_q + $signed((GPW+1)'(32768));
  assign es_c   = lprod_q + (gs_c >>> 16);
  assign nd_c   = -d;

  mrgf_expneg u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (ex_start),
    .x     (ex_x),
    .done  (ex_done),
    .val   (ex_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      done     <= 1'b0;
      ex_start <= 1'b0;
    end else begin
      done     <= 1'b0;
      ex_start <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start_e) begin
            diff_q <= diff_c;
            state  <= E_SQ;
          end else if (start_acc) begin
            if (!d[mrgf_pkg::E_W]) begin
              acc  <= 1'b1;
              done <= 1'b1;
            end else begin
              ex_x     <= (nd_c >= $signed((mrgf_pkg::E_W+2)'(mrgf_pkg::EXP_LIMIT)))
                          ? XIW'(mrgf_pkg::EXP_LIMIT) : nd_c[XIW-1:0];
              ex_start <= 1'b1;
              state    <= A_WAIT;
            end
          end
        end
        E_SQ: begin
          sq_q    <= $unsigned(sq_c);
          lprod_q <= lp_c;
          state   <= E_RATE;
        end
        E_RATE: begin
          ex_x     <= (xw_c >= XW'(mrgf_pkg::EXP_LIMIT)) ? XIW'(mrgf_pkg::EXP_LIMIT)
                      : xw_c[XIW-1:0];
          ex_start <= 1'b1;
          state    <= E_WAIT;
        end
        E_WAIT: begin
          if (ex_done) begin
            gprod_q <= gp_c;
            state   <= E_SUM;
          end
        end
        E_SUM: begin
          if (es_c > mrgf_pkg::E_MAX) begin
            e <= mrgf_pkg::E_MAX;
          end else if (es_c < mrgf_pkg::E_MIN) begin
            e <= mrgf_pkg::E_MIN;
          end else begin
            e <= es_c[mrgf_pkg::E_W-1:0];
          end
          done  <= 1'b1;
          state <= E_IDLE;
        end
        A_WAIT: begin
          if (ex_done) begin
            acc   <= ({1'b0, draw} <= ex_val);
            done  <= 1'b1;
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mrgf_grid.sv -----
// Grid store and search engine: flip, bounded searches, link updates and rollback.
module mrgf_grid #(
  parameter int GRID_SIDE = mrgf_pkg::GRID_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mrgf_pkg::grid_req_t               req,
  input  logic [$clog2(GRID_SIDE)-1:0]      row,
  input  logic [$clog2(GRID_SIDE)-1:0]      col,
  input  logic [mrgf_pkg::REACH_W-1:0]      reach,
  output mrgf_pkg::grid_stat_t              stat,
  output logic [2*$clog2(GRID_SIDE*GRID_SIDE)-1:0] total_double,
  output logic [$clog2(GRID_SIDE*GRID_SIDE):0]     buildings
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(CELLS);
  localparam int RCW   = $clog2(GRID_SIDE);
  localparam int TW    = 2 * CW;
  localparam int BW    = CW + 1;
  localparam int NW    = CW + 1;
  localparam int DW2   = 2 * CW;
  localparam int QW    = 2 * RCW;
  localparam int HTW   = QW + CW;
  localparam int VW    = mrgf_pkg::DIST_W + 1;

  typedef enum logic [4:0] {
    G_CLR, G_IDLE, G_FRD, G_FWR, G_SINIT, G_QRD, G_CRD, G_EVAL, G_NRD, G_NCHK,
    G_SW, G_HLOOP, G_HGET, G_LRD, G_LWR, G_UQ, G_URD, G_UWR, G_UFRD, G_UFWR
  } gstate_t;

  // Cell word: occupancy over link count. Visit word: seen over distance.
  logic [CW:0]     cell_mem  [CELLS];
  logic [VW-1:0]   visit_mem [CELLS];
  logic [QW-1:0]   queue_mem [CELLS];
  logic [HTW-1:0]  hit_mem   [CELLS];

  logic c_re, c_we, v_re, v_we, q_re, q_we, h_re, h_we;
  logic [CW-1:0]  c_raddr, c_waddr, v_raddr, v_waddr, q_raddr, q_waddr, h_raddr, h_waddr;
  logic [CW:0]    c_wdata, c_rdata;
  logic [VW-1:0]  v_wdata, v_rdata;
  logic [QW-1:0]  q_wdata, q_rdata;
  logic [HTW-1:0] h_wdata, h_rdata;

  gstate_t        state;
  logic [CW-1:0]  clr_a;
  logic [RCW-1:0] f_row, f_col, s_row, s_col, cur_row, cur_col, h_row, h_col, u_row, u_col;
  logic [RCW-1:0] n_row, n_col;
  logic           n_ok;
  logic [mrgf_pkg::DIST_W-1:0] cur_d;
  logic           outer;
  logic [NW-1:0]  head, tail, hits, nhits, k, sw_i;
  logic [1:0]     nb;
  logic           sw_pend;
  logic           saved_occ;
  logic [TW-1:0]  total, saved_total;
  logic [BW-1:0]  bld, saved_bld;
  logic [CW-1:0]  u_link;
  logic           done;

  // Evaluation views of the read data.
  logic [mrgf_pkg::DIST_W-1:0] ev_d;
  logic           ev_occ;
  logic           ev_hit;
  logic [CW-1:0]  new_link;
  logic           sw_more;

  function automatic logic [CW-1:0] idx(input logic [RCW-1:0] r, input logic [RCW-1:0] c);
    logic [DW2-1:0] t;
    t = DW2'(r) * DW2'(GRID_SIDE) + DW2'(c);
    return t[CW-1:0];
  endfunction

  assign ev_d     = v_rdata[mrgf_pkg::DIST_W-1:0];
  assign ev_occ   = c_rdata[CW];
  assign ev_hit   = ev_occ || (ev_d == '0);
  assign new_link = c_rdata[CW] ? CW'(hits - NW'(1)) : '0;
  assign sw_more  = (sw_i < tail);

  always_comb begin
    n_row = cur_row;
    n_col = cur_col;
    n_ok  = 1'b0;
    case (nb)
      2'd0: begin
        n_col = cur_col + RCW'(1);
        n_ok  = ((RCW+1)'(cur_col) + (RCW+1)'(1)) < (RCW+1)'(GRID_SIDE);
      end
      2'd1: begin
        n_col = cur_col - RCW'(1);
        n_ok  = (cur_col != '0);
      end
      2'd2: begin
        n_row = cur_row + RCW'(1);
        n_ok  = ((RCW+1)'(cur_row) + (RCW+1)'(1)) < (RCW+1)'(GRID_SIDE);
      end
      default: begin
        n_row = cur_row - RCW'(1);
        n_ok  = (cur_row != '0);
      end
    endcase
  end

  always_comb begin
    c_re = 1'b0; c_we = 1'b0; c_raddr = '0; c_waddr = '0; c_wdata = '0;
    v_re = 1'b0; v_we = 1'b0; v_raddr = '0; v_waddr = '0; v_wdata = '0;
    q_re = 1'b0; q_we = 1'b0; q_raddr = '0; q_waddr = '0; q_wdata = '0;
    h_re = 1'b0; h_we = 1'b0; h_raddr = '0; h_waddr = '0; h_wdata = '0;
    unique case (state)
      G_CLR: begin
        c_we = 1'b1; c_waddr = clr_a;
        v_we = 1'b1; v_waddr = clr_a;
      end
      G_FRD: begin
        c_re = 1'b1; c_raddr = idx(f_row, f_col);
      end
      G_FWR: begin
        c_we = 1'b1; c_waddr = idx(f_row, f_col);
        c_wdata = {~c_rdata[CW], c_rdata[CW-1:0]};
      end
      G_SINIT: begin
        v_we = 1'b1; v_waddr = idx(s_row, s_col); v_wdata = {1'b1, {mrgf_pkg::DIST_W{1'b0}}};
        q_we = 1'b1; q_waddr = '0; q_wdata = {s_row, s_col};
      end
      G_QRD: begin
        q_re = (head != tail); q_raddr = head[CW-1:0];
      end
      G_CRD: begin
        c_re = 1'b1; c_raddr = idx(q_rdata[QW-1:RCW], q_rdata[RCW-1:0]);
        v_re = 1'b1; v_raddr = idx(q_rdata[QW-1:RCW], q_rdata[RCW-1:0]);
      end
      G_EVAL: begin
        h_we    = outer && ev_hit && !(ev_d > reach);
        h_waddr = hits[CW-1:0];
        h_wdata = {cur_row, cur_col, {CW{1'b0}}};
      end
      G_NRD: begin
        v_re = n_ok; v_raddr = idx(n_row, n_col);
      end
      G_NCHK: begin
        if (!v_rdata[VW-1] && (tail < NW'(CELLS))) begin
          v_we = 1'b1; v_waddr = idx(n_row, n_col); v_wdata = {1'b1, cur_d + 6'd1};
          q_we = 1'b1; q_waddr = tail[CW-1:0]; q_wdata = {n_row, n_col};
        end
      end
      G_SW: begin
        q_re = sw_more; q_raddr = sw_i[CW-1:0];
        v_we = sw_pend; v_waddr = idx(q_rdata[QW-1:RCW], q_rdata[RCW-1:0]);
      end
      G_HLOOP: begin
        h_re = (k != nhits); h_raddr = k[CW-1:0];
      end
      G_LRD: begin
        c_re = 1'b1; c_raddr = idx(h_row, h_col);
      end
      G_LWR: begin
        c_we = 1'b1; c_waddr = idx(h_row, h_col); c_wdata = {c_rdata[CW], new_link};
        h_we = 1'b1; h_waddr = k[CW-1:0]; h_wdata = {h_row, h_col, c_rdata[CW-1:0]};
      end
      G_UQ: begin
        h_re = (k != nhits); h_raddr = k[CW-1:0];
      end
      G_URD: begin
        c_re = 1'b1; c_raddr = idx(h_rdata[HTW-1:RCW+CW], h_rdata[RCW+CW-1:CW]);
      end
      G_UWR: begin
        c_we = 1'b1; c_waddr = idx(u_row, u_col); c_wdata = {c_rdata[CW], u_link};
      end
      G_UFRD: begin
        c_re = 1'b1; c_raddr = idx(f_row, f_col);
      end
      G_UFWR: begin
        c_we = 1'b1; c_waddr = idx(f_row, f_col); c_wdata = {saved_occ, c_rdata[CW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) cell_mem[c_waddr] <= c_wdata;
    if (c_re) c_rdata <= cell_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) visit_mem[v_waddr] <= v_wdata;
    if (v_re) v_rdata <= visit_mem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    if (q_re) q_rdata <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hit_mem[h_waddr] <= h_wdata;
    if (h_re) h_rdata <= hit_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_CLR;
      clr_a <= '0;
      done  <= 1'b0;
      total <= '0;
      bld   <= '0;
      nhits <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_CLR: begin
          clr_a <= clr_a + CW'(1);
          if (clr_a == CW'(CELLS - 1)) begin
            state <= G_IDLE;
          end
        end
        G_IDLE: begin
          if (req.update) begin
            f_row <= row;
            f_col <= col;
            state <= G_FRD;
          end else if (req.undo) begin
            k     <= '0;
            state <= G_UQ;
          end
        end
        G_FRD: state <= G_FWR;
        G_FWR: begin
          saved_occ   <= c_rdata[CW];
          saved_total <= total;
          saved_bld   <= bld;
          bld         <= c_rdata[CW] ? bld - BW'(1) : bld + BW'(1);
          s_row       <= f_row;
          s_col       <= f_col;
          outer       <= 1'b1;
          state       <= G_SINIT;
        end
        G_SINIT: begin
          head  <= '0;
          tail  <= NW'(1);
          hits  <= '0;
          state <= G_QRD;
        end
        G_QRD: begin
          if (head == tail) begin
            sw_i    <= '0;
            sw_pend <= 1'b0;
            state   <= G_SW;
          end else begin
            head  <= head + NW'(1);
            state <= G_CRD;
          end
        end
        G_CRD: begin
          cur_row <= q_rdata[QW-1:RCW];
          cur_col <= q_rdata[RCW-1:0];
          state   <= G_EVAL;
        end
        G_EVAL: begin
          cur_d <= ev_d;
          if (ev_d > reach) begin
            sw_i    <= '0;
            sw_pend <= 1'b0;
            state   <= G_SW;
          end else begin
            if (ev_hit) begin
              hits <= hits + NW'(1);
            end
            if (ev_occ && (ev_d != '0)) begin
              state <= G_QRD;
            end else begin
              nb    <= '0;
              state <= G_NRD;
            end
          end
        end
        G_NRD: begin
          if (n_ok) begin
            state <= G_NCHK;
          end else if (nb == 2'd3) begin
            state <= G_QRD;
          end else begin
            nb <= nb + 2'd1;
          end
        end
        G_NCHK: begin
          if (!v_rdata[VW-1] && (tail < NW'(CELLS))) begin
            tail <= tail + NW'(1);
          end
          if (nb == 2'd3) begin
            state <= G_QRD;
          end else begin
            nb    <= nb + 2'd1;
            state <= G_NRD;
          end
        end
        G_SW: begin
          // Clears the seen marks of every queued cell, one cell a cycle.
          sw_pend <= sw_more;
          if (sw_more) begin
            sw_i <= sw_i + NW'(1);
          end else if (!sw_pend) begin
            if (outer) begin
              nhits <= hits;
              k     <= '0;
              state <= G_HLOOP;
            end else begin
              state <= G_LRD;
            end
          end
        end
        G_HLOOP: begin
          if (k == nhits) begin
            done  <= 1'b1;
            state <= G_IDLE;
          end else begin
            state <= G_HGET;
          end
        end
        G_HGET: begin
          s_row <= h_rdata[HTW-1:RCW+CW];
          s_col <= h_rdata[RCW+CW-1:CW];
          h_row <= h_rdata[HTW-1:RCW+CW];
          h_col <= h_rdata[RCW+CW-1:CW];
          outer <= 1'b0;
          state <= G_SINIT;
        end
        G_LRD: state <= G_LWR;
        G_LWR: begin
          total <= total + TW'(new_link) - TW'(c_rdata[CW-1:0]);
          k     <= k + NW'(1);
          state <= G_HLOOP;
        end
        G_UQ: begin
          if (k == nhits) begin
            state <= G_UFRD;
          end else begin
            state <= G_URD;
          end
        end
        G_URD: begin
          u_row  <= h_rdata[HTW-1:RCW+CW];
          u_col  <= h_rdata[RCW+CW-1:CW];
          u_link <= h_rdata[CW-1:0];
          state  <= G_UWR;
        end
        G_UWR: begin
          k     <= k + NW'(1);
          state <= G_UQ;
        end
        G_UFRD: state <= G_UFWR;
        G_UFWR: begin
          total <= saved_total;
          bld   <= saved_bld;
          done  <= 1'b1;
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign stat.ready   = (state == G_IDLE);
  assign stat.done    = done;
  assign total_double = total;
  assign buildings    = bld;

endmodule

// ----- src/metropolis_reach_grid_flip.sv -----
// Top level of the reach-grid Metropolis flip block: item handshakes, registers, sequencing.
//
//  channel  | handshake            | payload                | direction
//  ---------+----------------------+------------------------+----------
//  in       | in_valid / in_ready  | in_item (row,col,draw) | into block
//  out      | out_valid / out_ready| out_item (acc,totals)  | out of block
//  cfg      | cfg_we               | cfg_index, cfg_data    | into block
//
// One item is worked at a time. An in-grid item takes two energy evaluations, a
// flip, a bounded search from the flipped cell plus one search from each cell it
// reaches that is occupied or is the flipped cell itself (each search reads every
// dequeued cell, tries its neighbors and clears the marks of every queued cell),
// and on rejection a restore of every relinked cell and of the flipped cell.
// The single-port read of the cell and visit memories sets that walk's pace.
// After reset a clearing pass over all GRID_SIDE*GRID_SIDE cells empties the grid;
// no item is accepted meanwhile, while configuration writes are taken as ever.
// A finished result waits in the output register without blocking the next item.
module metropolis_reach_grid_flip #(
  parameter int GRID_SIDE = mrgf_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mrgf_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mrgf_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [mrgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrgf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(CELLS);
  localparam int RCW   = $clog2(GRID_SIDE);
  localparam int TW    = 2 * CW;
  localparam int BW    = CW + 1;

  typedef enum logic [2:0] {T_IDLE, T_OLD, T_GRID, T_NEW, T_ACC, T_UNDO, T_FIN} tstate_t;

  tstate_t                state;
  mrgf_pkg::cfg_t         cfg;
  mrgf_pkg::grid_req_t    g_req;
  mrgf_pkg::grid_stat_t   g_stat;
  logic [RCW-1:0]         cell_row, cell_col;
  logic [15:0]            draw;
  logic                   acc_bit;
  logic                   e_start, acc_start, e_done, e_acc;
  logic signed [mrgf_pkg::E_W-1:0] e_val, old_e;
  logic signed [mrgf_pkg::E_W:0]   d_c;
  logic [TW-1:0]          g_total;
  logic [BW-1:0]          g_bld;
  logic                   in_grid;
  logic                   take;

  assign in_ready = (state == T_IDLE) && g_stat.ready;
  assign take     = in_valid && in_ready;
  assign in_grid  = (7'(in_item.pos_row) < 7'(GRID_SIDE)) &&
                    (7'(in_item.pos_col) < 7'(GRID_SIDE));
  // Energy drop from before the flip to after it.
  assign d_c      = old_e - e_val;

  // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reach_limit      <= 6'd3;
      cfg.link_weight      <= '0;
      cfg.target_buildings <= '0;
      cfg.gauss_amp        <= '0;
      cfg.gauss_rate       <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrgf_pkg::CFG_REACH_LIMIT:      cfg.reach_limit      <= cfg_data[5:0];
        mrgf_pkg::CFG_LINK_WEIGHT:      cfg.link_weight      <= cfg_data;
        mrgf_pkg::CFG_TARGET_BUILDINGS: cfg.target_buildings <= cfg_data[10:0];
        mrgf_pkg::CFG_GAUSS_AMP:        cfg.gauss_amp        <= cfg_data;
        mrgf_pkg::CFG_GAUSS_RATE:       cfg.gauss_rate       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mrgf_grid #(
    .GRID_SIDE (GRID_SIDE)
  ) u_grid (
    .clk          (clk),
    .rst          (rst),
    .req          (g_req),
    .row          (cell_row),
    .col          (cell_col),
    .reach        (cfg.reach_limit),
    .stat         (g_stat),
    .total_double (g_total),
    .buildings    (g_bld)
  );

  mrgf_energy #(
    .BW (BW),
    .HW (TW - 1)
  ) u_energy (
    .clk       (clk),
    .rst       (rst),
    .start_e   (e_start),
    .start_acc (acc_start),
    .cfg       (cfg),
    .bld       (g_bld),
    .half      (g_total[TW-1:1]),
    .d         (d_c),
    .draw      (draw),
    .done      (e_done),
    .e         (e_val),
    .acc       (e_acc)
  );

  // Sequencer: old energy, flip and relink, new energy, test, optional rollback; off-grid items skip to the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      e_start   <= 1'b0;
      acc_start <= 1'b0;
      g_req     <= '0;
    end else begin
      e_start   <= 1'b0;
      acc_start <= 1'b0;
      g_req     <= '0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (take) begin
            cell_row <= RCW'(in_item.pos_row);
            cell_col <= RCW'(in_item.pos_col);
            draw     <= in_item.accept_draw;
            acc_bit  <= 1'b0;
            if (in_grid) begin
              e_start <= 1'b1;
              state   <= T_OLD;
            end else begin
              state <= T_FIN;
            end
          end
        end
        T_OLD: begin
          if (e_done) begin
            old_e        <= e_val;
            g_req.update <= 1'b1;
            state        <= T_GRID;
          end
        end
        T_GRID: begin
          if (g_stat.done) begin
            e_start <= 1'b1;
            state   <= T_NEW;
          end
        end
        T_NEW: begin
          if (e_done) begin
            acc_start <= 1'b1;
            state     <= T_ACC;
          end
        end
        T_ACC: begin
          if (e_done) begin
            acc_bit <= e_acc;
            if (e_acc) begin
              state <= T_FIN;
            end else begin
              g_req.undo <= 1'b1;
              state      <= T_UNDO;
            end
          end
        end
        T_UNDO: begin
          if (g_stat.done) begin
            state <= T_FIN;
          end
        end
        T_FIN: begin
          // The result goes out once the output register is free.
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_item.accepted        <= acc_bit;
            out_item.total_links     <= 19'(g_total >> 1);
            out_item.total_buildings <= 11'(g_bld);
            state                    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
